@@ design/ugbi_pkg.sv @@
// ----------------------------------------------------------------------------
// ugbi_pkg: shared types and constants for the uniform grid bin index core
// Field widths, configuration register codes, result status codes and the
// control bundle handed from the top level to the merge stage.
// ----------------------------------------------------------------------------
package ugbi_pkg;

    // fixed field widths
    localparam int COORD_W   = 32;
    localparam int BINS_W    = 11;
    localparam int AXES_W    = 2;
    localparam int INDEX_W   = 20;
    localparam int CFG_IDX_W = 3;

    // largest bin count the bins field can hold
    localparam int BINS_FIELD_MAX = (1 << BINS_W) - 1;

    // defaults for the top-level parameters
    localparam int DEF_MAX_BINS_PER_AXIS = 1024;
    localparam int DEF_NUM_AXES          = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXES        = 3'd0,
        REG_AXIS0_START = 3'd1,
        REG_AXIS0_STOP  = 3'd2,
        REG_AXIS0_BINS  = 3'd3,
        REG_AXIS1_START = 3'd4,
        REG_AXIS1_STOP  = 3'd5,
        REG_AXIS1_BINS  = 3'd6
    } cfg_reg_t;

    // per-axis register codes, indexed by axis number
    localparam cfg_reg_t AXIS_START_REG [0:1] = '{REG_AXIS0_START, REG_AXIS1_START};
    localparam cfg_reg_t AXIS_STOP_REG  [0:1] = '{REG_AXIS0_STOP,  REG_AXIS1_STOP};
    localparam cfg_reg_t AXIS_BINS_REG  [0:1] = '{REG_AXIS0_BINS,  REG_AXIS1_BINS};

    // register reset values
    localparam logic [AXES_W-1:0]         AXES_RESET  = 2'd2;
    localparam logic signed [COORD_W-1:0] START_RESET = 32'sd0;
    localparam logic signed [COORD_W-1:0] STOP_RESET  = 32'sd65536;
    localparam logic [BINS_W-1:0]         BINS_RESET  = 11'd1;

    // result status codes
    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_BELOW = 2'd1,
        ST_ABOVE = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    // configuration view used by the merge stage
    typedef struct packed {
        logic              use2;
        logic              bad;
        logic [BINS_W-1:0] bins0;
    } merge_cfg_t;

endpackage

@@ design/ugbi_divider.sv @@
// ----------------------------------------------------------------------------
// ugbi_divider: pipelined restoring divider
// One quotient bit per stage; the dividend is known to be below
// divisor * 2**QW, so QW stages give the full quotient. A status code
// rides along with each request.
// ----------------------------------------------------------------------------
module ugbi_divider #(
    parameter int QW = 10
) (
    input  logic                                    clk,
    input  logic [ugbi_pkg::COORD_W+ugbi_pkg::BINS_W-1:0] dividend,
    input  logic [ugbi_pkg::COORD_W-1:0]            divisor,
    input  ugbi_pkg::status_t                       st_in,
    output logic [QW-1:0]                           quo,
    output ugbi_pkg::status_t                       st_out
);

    localparam int DW = ugbi_pkg::COORD_W + ugbi_pkg::BINS_W;
    localparam int RW = ugbi_pkg::COORD_W;

    // top part of the dividend is already below the divisor
    logic [DW-1:0] dividend_sh;
    assign dividend_sh = dividend >> QW;

    // stage registers, stage k result at index k+1
    logic [RW-1:0]     rem_reg [1:QW];
    logic [QW-1:0]     low_reg [1:QW];
    logic [QW-1:0]     quo_reg [1:QW];
    ugbi_pkg::status_t st_reg  [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0]     rem_cur;
        logic [QW-1:0]     low_cur;
        logic [QW-1:0]     quo_cur;
        ugbi_pkg::status_t st_cur;
        logic [RW:0]       trial;
        logic [RW:0]       trial_sub;
        logic              ge;

        // pick the stage source
        if (k == 0) begin : g_first
            assign rem_cur = dividend_sh[RW-1:0];
            assign low_cur = dividend[QW-1:0];
            assign quo_cur = '0;
            assign st_cur  = st_in;
        end
        else begin : g_next
            assign rem_cur = rem_reg[k];
            assign low_cur = low_reg[k];
            assign quo_cur = quo_reg[k];
            assign st_cur  = st_reg[k];
        end

        // bring down one dividend bit and try the subtract
        assign trial     = {rem_cur, low_cur[QW-1]};
        assign trial_sub = trial - {1'b0, divisor};
        assign ge        = (trial >= {1'b0, divisor});

        // advance one stage
        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? trial_sub[RW-1:0] : trial[RW-1:0];
            low_reg[k+1] <= low_cur << 1;
            quo_reg[k+1] <= (quo_cur << 1) | QW'(ge);
            st_reg[k+1]  <= st_cur;
        end
    end

    assign quo    = quo_reg[QW];
    assign st_out = st_reg[QW];

endmodule

@@ design/ugbi_lane.sv @@
// ----------------------------------------------------------------------------
// ugbi_lane: one axis of the bin computation
// Range check and offset, scale by the bin count, then divide by the axis
// span to get the axis bin. The offset and the product are each registered ahead of the divider; one request per cycle.
// ----------------------------------------------------------------------------
module ugbi_lane #(
    parameter int QW = 10
) (
    input  logic                                  clk,
    input  logic signed [ugbi_pkg::COORD_W-1:0]   x,
    input  logic signed [ugbi_pkg::COORD_W-1:0]   lo,
    input  logic signed [ugbi_pkg::COORD_W-1:0]   hi,
    input  logic [ugbi_pkg::BINS_W-1:0]           bin_count,
    output logic [QW-1:0]                         quo,
    output ugbi_pkg::status_t                     st
);

    localparam int CW = ugbi_pkg::COORD_W;
    localparam int DW = ugbi_pkg::COORD_W + ugbi_pkg::BINS_W;

    logic [CW:0]           offset;
    logic [CW-1:0]         span;
    ugbi_pkg::status_t     st_chk;
    logic [CW-1:0]         diff_reg;
    ugbi_pkg::status_t     st1_reg;
    logic [DW-1:0]         prod_reg;
    ugbi_pkg::status_t     st2_reg;

    // check the range, stop edge first
    always_comb
    begin
        if (x >= hi)
            st_chk = ugbi_pkg::ST_ABOVE;
        else if (x < lo)
            st_chk = ugbi_pkg::ST_BELOW;
        else
            st_chk = ugbi_pkg::ST_FOUND;
    end

    assign offset = {x[CW-1], x} - {lo[CW-1], lo};
    assign span   = CW'(hi - lo);

    // hold the offset from the lower edge
    always_ff @(posedge clk)
    begin
        diff_reg <= offset[CW-1:0];
        st1_reg  <= st_chk;
    end

    // scale by the bin count
    always_ff @(posedge clk)
    begin
        prod_reg <= DW'(diff_reg) * DW'(bin_count);
        st2_reg  <= st1_reg;
    end

    ugbi_divider #(
        .QW (QW)
    ) u_div (
        .clk      (clk),
        .dividend (prod_reg),
        .divisor  (span),
        .st_in    (st2_reg),
        .quo      (quo),
        .st_out   (st)
    );

endmodule

@@ design/ugbi_merge.sv @@
// ----------------------------------------------------------------------------
// ugbi_merge: combine the lane results into one global bin
// Resolve the status in axis order, scale the axis 1 bin by the axis 0 bin
// count, then add and drive the result strobe.
// ----------------------------------------------------------------------------
module ugbi_merge #(
    parameter int QW       = 10,
    parameter int NUM_AXES = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [QW-1:0]                     quo [NUM_AXES],
    input  ugbi_pkg::status_t                 st  [NUM_AXES],
    input  ugbi_pkg::merge_cfg_t              cfg,
    output logic                              done,
    output logic [ugbi_pkg::INDEX_W-1:0]      bin_index,
    output logic [1:0]                        status
);

    localparam int PW = QW + ugbi_pkg::BINS_W;
    localparam int SW = PW + 1;

    logic [QW-1:0]         b1;
    ugbi_pkg::status_t     st1;
    ugbi_pkg::status_t     st_res;
    logic                  v1_reg;
    logic [QW-1:0]         b0_reg;
    logic [PW-1:0]         prod_reg;
    ugbi_pkg::status_t     st_reg;
    logic                  use2_reg;
    logic [SW-1:0]         sum;
    logic                  done_reg;
    logic [ugbi_pkg::INDEX_W-1:0] bin_reg;
    ugbi_pkg::status_t     status_reg;

    // second lane, when present
    if (NUM_AXES > 1) begin : g_two
        assign b1  = quo[1];
        assign st1 = st[1];
    end
    else begin : g_one
        assign b1  = '0;
        assign st1 = ugbi_pkg::ST_FOUND;
    end

    // resolve status: bad configuration, then axis 0, then axis 1
    always_comb
    begin
        if (cfg.bad)
            st_res = ugbi_pkg::ST_BAD;
        else if (st[0] != ugbi_pkg::ST_FOUND)
            st_res = st[0];
        else if (cfg.use2 && (st1 != ugbi_pkg::ST_FOUND))
            st_res = st1;
        else
            st_res = ugbi_pkg::ST_FOUND;
    end

    // stage one: row offset product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        b0_reg   <= quo[0];
        prod_reg <= PW'(b1) * PW'(cfg.bins0);
        st_reg   <= st_res;
        use2_reg <= cfg.use2;
    end

    // stage two: add and drop the index unless found
    assign sum = use2_reg ? (SW'(b0_reg) + SW'(prod_reg)) : SW'(b0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        bin_reg    <= (st_reg == ugbi_pkg::ST_FOUND) ? ugbi_pkg::INDEX_W'(sum) : '0;
        status_reg <= st_reg;
    end

    assign done      = done_reg;
    assign bin_index = bin_reg;
    assign status    = status_reg;

endmodule

@@ design/uniform_grid_bin_index_core.sv @@
// ----------------------------------------------------------------------------
// uniform_grid_bin_index_core: map a point to its uniform grid bin
// Start passes the lane offset and product registers, the per-axis
// divider, one quotient bit per stage, and the merge registers before done;
// QW = ceil(log2(max bins)) with max bins capped at 2047. Throughput: one
// request per cycle, busy stays low. Reset clears the pipeline valids and
// loads the register reset values; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module uniform_grid_bin_index_core #(
    parameter int MAX_BINS_PER_AXIS = ugbi_pkg::DEF_MAX_BINS_PER_AXIS,
    parameter int NUM_AXES          = ugbi_pkg::DEF_NUM_AXES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ugbi_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [ugbi_pkg::COORD_W-1:0]         cfg_wdata,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [ugbi_pkg::COORD_W-1:0]  coord_a,
    input  logic signed [ugbi_pkg::COORD_W-1:0]  coord_b,
    output logic                                 done,
    output logic [ugbi_pkg::INDEX_W-1:0]         bin_index,
    output logic [1:0]                           status
);

    localparam int EFF_BINS = (MAX_BINS_PER_AXIS < ugbi_pkg::BINS_FIELD_MAX) ?
                              MAX_BINS_PER_AXIS : ugbi_pkg::BINS_FIELD_MAX;
    localparam int QW       = (EFF_BINS > 1) ? $clog2(EFF_BINS) : 1;
    localparam int LANE_LAT = QW + 2;
    localparam int LAT      = QW + 4;

    localparam int CW = ugbi_pkg::COORD_W;
    localparam int BW = ugbi_pkg::BINS_W;

    ugbi_pkg::cfg_reg_t        addr_code;
    logic [ugbi_pkg::AXES_W-1:0] axes_reg;
    logic signed [CW-1:0]      start_reg [NUM_AXES];
    logic signed [CW-1:0]      stop_reg  [NUM_AXES];
    logic [BW-1:0]             bins_reg  [NUM_AXES];
    logic [NUM_AXES-1:0]       axis_bad;
    logic [NUM_AXES-1:0]       axis_used;
    logic                      use2;
    logic                      accept;
    logic [LANE_LAT-1:0]       valid_reg;
    logic [QW-1:0]             lane_quo [NUM_AXES];
    ugbi_pkg::status_t         lane_st  [NUM_AXES];
    ugbi_pkg::merge_cfg_t      merge_cfg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign addr_code = ugbi_pkg::cfg_reg_t'(cfg_addr);

    // axis count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            axes_reg <= ugbi_pkg::AXES_RESET;
        else if (cfg_we && (addr_code == ugbi_pkg::REG_AXES))
            axes_reg <= cfg_wdata[ugbi_pkg::AXES_W-1:0];
    end

    // a zero axis count acts as one
    assign use2 = (NUM_AXES > 1) && (axes_reg >= 2'd2);

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        logic signed [CW-1:0] lane_x;

        // per-axis edge and bin count registers
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                start_reg[a] <= ugbi_pkg::START_RESET;
                stop_reg[a]  <= ugbi_pkg::STOP_RESET;
                bins_reg[a]  <= ugbi_pkg::BINS_RESET;
            end
            else if (cfg_we)
            begin
                if (addr_code == ugbi_pkg::AXIS_START_REG[a])
                    start_reg[a] <= cfg_wdata;
                if (addr_code == ugbi_pkg::AXIS_STOP_REG[a])
                    stop_reg[a] <= cfg_wdata;
                if (addr_code == ugbi_pkg::AXIS_BINS_REG[a])
                    bins_reg[a] <= cfg_wdata[BW-1:0];
            end
        end

        // flag an empty span or a bin count out of range
        assign axis_bad[a] = (start_reg[a] >= stop_reg[a]) ||
                             (bins_reg[a] == '0) ||
                             (32'(bins_reg[a]) > 32'(MAX_BINS_PER_AXIS));
        assign axis_used[a] = (a == 0) || use2;

        assign lane_x = (a == 0) ? coord_a : coord_b;

        ugbi_lane #(
            .QW (QW)
        ) u_lane (
            .clk       (clk),
            .x         (lane_x),
            .lo        (start_reg[a]),
            .hi        (stop_reg[a]),
            .bin_count (bins_reg[a]),
            .quo       (lane_quo[a]),
            .st        (lane_st[a])
        );
    end

    // track requests through the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LANE_LAT-2:0], accept};
    end

    assign merge_cfg.use2  = use2;
    assign merge_cfg.bad   = |(axis_bad & axis_used);
    assign merge_cfg.bins0 = bins_reg[0];

    ugbi_merge #(
        .QW       (QW),
        .NUM_AXES (NUM_AXES)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_reg[LANE_LAT-1]),
        .quo       (lane_quo),
        .st        (lane_st),
        .cfg       (merge_cfg),
        .done      (done),
        .bin_index (bin_index),
        .status    (status)
    );

    // a result only appears for a matching accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
    else $error("result strobe without a matching request");

    // index is zero unless the point was found
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ugbi_pkg::ST_FOUND)) |-> (bin_index == '0))
    else $error("nonzero bin index on a miss");

endmodule
